[hdl/zzr_pkg.sv]
`timescale 1ns / 1ps

package zzr_pkg;

  localparam int unsigned COEFF_BITS = 16;
  localparam int unsigned BLOCK_SIZE = 64;
  localparam int unsigned IDX_W      = $clog2(BLOCK_SIZE);
  // Two banks: one fills while the other drains.
  localparam int unsigned RAM_DEPTH  = 2 * BLOCK_SIZE;
  localparam int unsigned RAM_ADDR_W = $clog2(RAM_DEPTH);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_SIZE - 1);

  // Raster position of each zigzag position.
  localparam logic [IDX_W-1:0] SCAN_ORDER [BLOCK_SIZE] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  typedef logic signed [COEFF_BITS-1:0] coeff_t;

  // Controller -> datapath
  typedef struct packed {
    logic wr;    // store the input word
    logic rd;    // issue one zigzag read
    logic swap;  // block complete: flip banks
  } zzr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic fill_last;  // next write is the 64th of the block
    logic rd_last;    // next read is the 64th of the drain
    logic out_free;   // output register can take a new word
  } zzr_status_t;

endpackage

[hdl/zzr_ifs.sv]
`timescale 1ns / 1ps

interface zzr_in_if;
  logic            valid;
  logic            ready;
  zzr_pkg::coeff_t coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

interface zzr_out_if;
  logic            valid;
  logic            ready;
  zzr_pkg::coeff_t zz_coefficient;
  logic            last_of_block;

  modport source (output valid, output zz_coefficient, output last_of_block, input ready);
  modport sink   (input valid, input zz_coefficient, input last_of_block, output ready);
endinterface

[hdl/zigzag_reorder_8x8_unit.sv]
`timescale 1ns / 1ps

// 8x8 zigzag reorder.
// Input channel coef_i: one signed coefficient per word, raster order
// (row by row, column by column), 64 words per block.
// Output channel zz_o: the same 64 coefficients in JPEG zigzag order;
// last_of_block is high on the 64th word of each block.
// Storage is one 128-entry RAM split in two banks: one bank fills while
// the other drains, so the next block loads during the current drain.
// Output start: after the 64th input word is taken, the controller enters
// drain and issues the first read, and the RAM read register loads that
// word; the rest follow one per cycle while zz_o.ready stays high, set by
// the single RAM read port. In sustained flow the word that completes a
// block waits (coef_i.ready low) for the last read of the previous drain,
// so the output also pauses between blocks.
// Receiver stall: the RAM read register holds the pending word and no new
// read is issued. Filling continues; only the word that would finish the
// next block waits (coef_i.ready low) until the current drain is done.
// Reset (rst_ni low, async): counters, bank select and output valid
// clear; RAM contents are not cleared and are never read before written.
module zigzag_reorder_8x8_unit (
  input logic      clk_i,
  input logic      rst_ni,
  zzr_in_if.sink   coef_i,
  zzr_out_if.source zz_o
);

  zzr_pkg::zzr_cmd_t    cmd;
  zzr_pkg::zzr_status_t status;
  logic                 in_ready;

  zzr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (coef_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  zzr_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .coefficient_i    (coef_i.coefficient),
    .zz_coefficient_o (zz_o.zz_coefficient),
    .last_of_block_o  (zz_o.last_of_block),
    .out_valid_o      (zz_o.valid),
    .out_ready_i      (zz_o.ready)
  );

  assign coef_i.ready = in_ready;

endmodule

[hdl/zzr_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one read port, registered read.
// Read data holds while rd_en_i is low.
module zzr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/zzr_datapath.sv]
`timescale 1ns / 1ps

module zzr_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  zzr_pkg::zzr_cmd_t    cmd_i,
  output zzr_pkg::zzr_status_t status_o,
  input  zzr_pkg::coeff_t      coefficient_i,
  output zzr_pkg::coeff_t      zz_coefficient_o,
  output logic                 last_of_block_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);

  logic [zzr_pkg::IDX_W-1:0]      wr_cnt_q, wr_cnt_d;
  logic [zzr_pkg::IDX_W-1:0]      rd_cnt_q, rd_cnt_d;
  logic                           wbank_q, wbank_d;
  logic                           out_valid_q, out_valid_d;
  logic                           last_q, last_d;
  logic [zzr_pkg::RAM_ADDR_W-1:0] wr_addr, rd_addr;
  logic [zzr_pkg::COEFF_BITS-1:0] rd_data;

  // Write bank fills, the other bank drains.
  assign wr_addr = {wbank_q, wr_cnt_q};
  assign rd_addr = {~wbank_q, zzr_pkg::SCAN_ORDER[rd_cnt_q]};

  always_comb begin
    wr_cnt_d    = cmd_i.wr ? wr_cnt_q + 1'b1 : wr_cnt_q;
    rd_cnt_d    = cmd_i.rd ? rd_cnt_q + 1'b1 : rd_cnt_q;
    wbank_d     = cmd_i.swap ? ~wbank_q : wbank_q;
    last_d      = cmd_i.rd ? (rd_cnt_q == zzr_pkg::LAST_IDX) : last_q;
    out_valid_d = cmd_i.rd | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      wbank_q     <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      wr_cnt_q    <= wr_cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      wbank_q     <= wbank_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  // RAM read register doubles as the output data register.
  zzr_ram #(
    .WIDTH (zzr_pkg::COEFF_BITS),
    .DEPTH (zzr_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr),
    .wr_addr_i (wr_addr),
    .wr_data_i (coefficient_i),
    .rd_en_i   (cmd_i.rd),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign zz_coefficient_o   = rd_data;
  assign last_of_block_o    = last_q;
  assign out_valid_o        = out_valid_q;
  assign status_o.fill_last = (wr_cnt_q == zzr_pkg::LAST_IDX);
  assign status_o.rd_last   = (rd_cnt_q == zzr_pkg::LAST_IDX);
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

endmodule

[hdl/zzr_ctrl.sv]
`timescale 1ns / 1ps

module zzr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  zzr_pkg::zzr_status_t status_i,
  output zzr_pkg::zzr_cmd_t    cmd_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state_q, state_d;
  logic accept;

  // Hold off the word that would finish a block while the other bank drains.
  assign in_ready_o = ~(status_i.fill_last & (state_q == ST_DRAIN));
  assign accept     = in_valid_i & in_ready_o;

  assign cmd_o.wr   = accept;
  assign cmd_o.swap = accept & status_i.fill_last;
  assign cmd_o.rd   = (state_q == ST_DRAIN) & status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.swap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmd_o.rd && status_i.rd_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_rd_only_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> state_q == ST_DRAIN)
    else $error("zigzag read issued outside drain");

  a_swap_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.swap |-> state_q == ST_IDLE)
    else $error("bank swap while previous block still draining");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && cmd_o.rd && status_i.rd_last) |=> state_q == ST_IDLE)
    else $error("drain did not end after 64th read");

  a_swap_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.swap |=> (state_q == ST_DRAIN && !status_i.fill_last))
    else $error("block completion did not start drain");

endmodule
